/* rtl/acs_pkg.sv */
package acs_pkg;

  localparam int MEM_WORDS_DEF = 256;

  // item opcodes
  localparam logic [1:0] ITEM_WRITE   = 2'd0;
  localparam logic [1:0] ITEM_READ    = 2'd1;
  localparam logic [1:0] ITEM_RESTART = 2'd2;
  localparam logic [1:0] ITEM_EXEC    = 2'd3;

  // configuration register indexes
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_WORDS = 1'b1;

  // instruction bytes
  localparam logic [7:0] OP_NOP = 8'h00;
  localparam logic [7:0] OP_STA = 8'h10;
  localparam logic [7:0] OP_LDA = 8'h20;
  localparam logic [7:0] OP_ADD = 8'h30;
  localparam logic [7:0] OP_OR  = 8'h40;
  localparam logic [7:0] OP_AND = 8'h50;
  localparam logic [7:0] OP_NOT = 8'h60;
  localparam logic [7:0] OP_JMP = 8'h80;
  localparam logic [7:0] OP_JN  = 8'h90;
  localparam logic [7:0] OP_JZ  = 8'hA0;
  localparam logic [7:0] OP_HLT = 8'hF0;

  typedef enum logic [1:0] {
    ASEL_ITEM,
    ASEL_PC,
    ASEL_PC1,
    ASEL_ARG
  } asel_t;

  typedef enum logic [2:0] {
    PC_HOLD,
    PC_INC1,
    PC_INC2,
    PC_JUMP,
    PC_START
  } pc_op_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_NOT,
    ACC_LOAD,
    ACC_ADD,
    ACC_OR,
    ACC_AND
  } acc_op_t;

  typedef struct packed {
    logic    mem_rd;
    logic    mem_wr;
    asel_t   asel;
    pc_op_t  pc_op;
    acc_op_t acc_op;
    logic    halt_set;
    logic    halt_clr;
    logic    halt_chk;
    logic    ir_load;
    logic    out_load;
    logic    out_rd;
  } cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] ir;
    logic       acc_neg;
    logic       acc_zero;
    logic       halted;
    logic       pc_end;
  } sts_t;

  typedef struct packed {
    logic [4:0] pad;
    logic [7:0] read_data;
    logic       halted;
    logic       zero_flag;
    logic       negative_flag;
    logic [7:0] program_counter;
    logic [7:0] accumulator;
  } result_t;

  typedef logic [7:0] mod_tab_t [256];

  function automatic logic two_word(input logic [7:0] op);
    return (op == OP_STA) || (op == OP_LDA) || (op == OP_ADD) || (op == OP_OR) ||
           (op == OP_AND) || (op == OP_JMP) || (op == OP_JN) || (op == OP_JZ);
  endfunction

  // byte value mod words, built by counting so no divider is involved
  function automatic mod_tab_t mod_table(input int words);
    mod_tab_t tab;
    int       r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'(r);
      if (r == words - 1) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tab;
  endfunction

endpackage

/* rtl/acs_ctrl.sv */
module acs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [1:0]    item_op,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  acs_pkg::sts_t sts,
  output acs_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OP   = 5'b00010,
    S_ARG  = 5'b00100,
    S_ALU  = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [1:0] kind, kind_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cmd.mem_rd   = 1'b0;
    cmd.mem_wr   = 1'b0;
    cmd.asel     = acs_pkg::ASEL_ITEM;
    cmd.pc_op    = acs_pkg::PC_HOLD;
    cmd.acc_op   = acs_pkg::ACC_HOLD;
    cmd.halt_set = 1'b0;
    cmd.halt_clr = 1'b0;
    cmd.halt_chk = 1'b0;
    cmd.ir_load  = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_rd   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          kind_next  = item_op;
          state_next = S_PUT;
          case (item_op)
            acs_pkg::ITEM_WRITE: begin
              cmd.mem_wr = 1'b1;
            end
            acs_pkg::ITEM_READ: begin
              cmd.mem_rd = 1'b1;
            end
            acs_pkg::ITEM_RESTART: begin
              cmd.pc_op    = acs_pkg::PC_START;
              cmd.acc_op   = acs_pkg::ACC_CLEAR;
              cmd.halt_clr = 1'b1;
            end
            acs_pkg::ITEM_EXEC: begin
              // halted or past the end: the end check in S_PUT does the rest
              if (!sts.halted && !sts.pc_end) begin
                cmd.mem_rd = 1'b1;
                cmd.asel   = acs_pkg::ASEL_PC;
                state_next = S_OP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_OP: begin
        cmd.ir_load = 1'b1;
        if (acs_pkg::two_word(sts.rdata)) begin
          cmd.mem_rd = 1'b1;
          cmd.asel   = acs_pkg::ASEL_PC1;
          cmd.pc_op  = acs_pkg::PC_INC2;
          state_next = S_ARG;
        end else begin
          cmd.pc_op = acs_pkg::PC_INC1;
          if (sts.rdata == acs_pkg::OP_NOT) begin
            cmd.acc_op = acs_pkg::ACC_NOT;
          end
          if (sts.rdata == acs_pkg::OP_HLT) begin
            cmd.halt_set = 1'b1;
          end
          state_next = S_PUT;
        end
      end
      S_ARG: begin
        // rdata holds the operand word here
        cmd.asel   = acs_pkg::ASEL_ARG;
        state_next = S_PUT;
        if (sts.ir inside {acs_pkg::OP_LDA, acs_pkg::OP_ADD, acs_pkg::OP_OR,
                           acs_pkg::OP_AND}) begin
          cmd.mem_rd = 1'b1;
          state_next = S_ALU;
        end else if (sts.ir == acs_pkg::OP_STA) begin
          cmd.mem_wr = 1'b1;
        end else if ((sts.ir == acs_pkg::OP_JMP) ||
                     ((sts.ir == acs_pkg::OP_JN) && sts.acc_neg) ||
                     ((sts.ir == acs_pkg::OP_JZ) && sts.acc_zero)) begin
          cmd.pc_op = acs_pkg::PC_JUMP;
        end
      end
      S_ALU: begin
        case (sts.ir)
          acs_pkg::OP_LDA: cmd.acc_op = acs_pkg::ACC_LOAD;
          acs_pkg::OP_ADD: cmd.acc_op = acs_pkg::ACC_ADD;
          acs_pkg::OP_OR:  cmd.acc_op = acs_pkg::ACC_OR;
          acs_pkg::OP_AND: cmd.acc_op = acs_pkg::ACC_AND;
          default:         cmd.acc_op = acs_pkg::ACC_HOLD;
        endcase
        state_next = S_PUT;
      end
      S_PUT: begin
        // end-of-program check is idempotent, so repeating it while stalled is harmless
        cmd.halt_chk = (kind == acs_pkg::ITEM_EXEC);
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          cmd.out_rd   = (kind == acs_pkg::ITEM_READ);
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      kind     <= acs_pkg::ITEM_WRITE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      kind     <= kind_next;
      m_tvalid <= cmd.out_load | (m_tvalid & ~m_tready);
    end
  end

endmodule

/* rtl/acs_dpath.sv */
module acs_dpath #(
  parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [8:0]       cfg_data,
  input  logic [7:0]       item_address,
  input  logic [7:0]       item_data,
  input  acs_pkg::cmd_t    cmd,
  output acs_pkg::sts_t    sts,
  output acs_pkg::result_t result
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int HiRem = 256 % MEM_WORDS;
  localparam acs_pkg::mod_tab_t ModTab = acs_pkg::mod_table(MEM_WORDS);

  logic [7:0]           mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid;
  logic [7:0]           mem_q;
  logic                 vld_q;

  logic [7:0] start_address;
  logic [8:0] program_words;
  logic [7:0] acc, acc_next;
  logic [8:0] pc, pc_next;
  logic       halt, halt_next;
  logic [7:0] ir;

  logic [7:0]    rdata;
  logic [8:0]    pc_inc1;
  logic [8:0]    maddr_raw;
  logic [8:0]    msum;
  logic [8:0]    mred;
  logic [AW-1:0] maddr;
  logic [7:0]    wdata;
  logic [8:0]    acc_sum;
  logic          pc_end;

  assign rdata   = vld_q ? mem_q : 8'd0;
  assign pc_inc1 = pc + 9'd1;
  assign pc_end  = (pc >= program_words);
  assign acc_sum = {1'b0, acc} + {1'b0, rdata};

  always_comb begin
    case (cmd.asel)
      acs_pkg::ASEL_ITEM: maddr_raw = {1'b0, item_address};
      acs_pkg::ASEL_PC:   maddr_raw = pc;
      acs_pkg::ASEL_PC1:  maddr_raw = pc_inc1;
      acs_pkg::ASEL_ARG:  maddr_raw = {1'b0, rdata};
      default:            maddr_raw = pc;
    endcase
    // address mod MEM_WORDS: table for the low byte, fold in bit 8, one correction
    msum = 9'(ModTab[maddr_raw[7:0]]) + (maddr_raw[8] ? 9'(HiRem) : 9'd0);
    if (msum >= 9'(MEM_WORDS)) begin
      mred = msum - 9'(MEM_WORDS);
    end else begin
      mred = msum;
    end
    maddr = mred[AW-1:0];
    wdata = (cmd.asel == acs_pkg::ASEL_ITEM) ? item_data : acc;
  end

  always_comb begin
    case (cmd.pc_op)
      acs_pkg::PC_HOLD:  pc_next = pc;
      acs_pkg::PC_INC1:  pc_next = pc_inc1;
      acs_pkg::PC_INC2:  pc_next = pc + 9'd2;
      acs_pkg::PC_JUMP:  pc_next = {1'b0, rdata};
      acs_pkg::PC_START: pc_next = {1'b0, start_address};
      default:           pc_next = pc;
    endcase
    case (cmd.acc_op)
      acs_pkg::ACC_HOLD:  acc_next = acc;
      acs_pkg::ACC_CLEAR: acc_next = 8'd0;
      acs_pkg::ACC_NOT:   acc_next = ~acc;
      acs_pkg::ACC_LOAD:  acc_next = rdata;
      acs_pkg::ACC_ADD:   acc_next = acc_sum[7:0];
      acs_pkg::ACC_OR:    acc_next = acc | rdata;
      acs_pkg::ACC_AND:   acc_next = acc & rdata;
      default:            acc_next = acc;
    endcase
    if (cmd.halt_clr) begin
      halt_next = 1'b0;
    end else begin
      halt_next = halt | cmd.halt_set | (cmd.halt_chk & pc_end);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[maddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      mem_q <= mem[maddr];
    end
  end

  // never-written words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (cmd.mem_wr) begin
        valid[maddr] <= 1'b1;
      end
      if (cmd.mem_rd) begin
        vld_q <= valid[maddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= 8'd0;
      program_words <= 9'd256;
      acc           <= 8'd0;
      pc            <= 9'd0;
      halt          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          acs_pkg::CFG_START: start_address <= cfg_data[7:0];
          acs_pkg::CFG_WORDS: program_words <= cfg_data;
          default: begin
          end
        endcase
      end
      acc  <= acc_next;
      pc   <= pc_next;
      halt <= halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ir_load) begin
      ir <= rdata;
    end
    if (cmd.out_load) begin
      result.pad             <= 5'd0;
      result.read_data       <= cmd.out_rd ? rdata : 8'd0;
      result.halted          <= halt_next;
      result.zero_flag       <= (acc == 8'd0);
      result.negative_flag   <= acc[7];
      result.program_counter <= pc[7:0];
      result.accumulator     <= acc;
    end
  end

  assign sts.rdata    = rdata;
  assign sts.ir       = ir;
  assign sts.acc_neg  = acc[7];
  assign sts.acc_zero = (acc == 8'd0);
  assign sts.halted   = halt;
  assign sts.pc_end   = pc_end;

endmodule

/* rtl/accumulator_cpu_step.sv */
// Eight-bit accumulator machine with a MEM_WORDS-byte program/data memory.
// Input stream (s_*): one word per command: write a memory byte, read one
// back, restart at start_address, or execute one instruction.
// Output stream (m_*): exactly one result word per input word, in order.
// Config port: cfg_we/cfg_index/cfg_data write start_address (index 0) and
// program_words (index 1); write only while no command is in flight.
// Steps per word: write, read, restart, and execute while halted or past
// the end go straight to the result; other instructions read the opcode,
// then the operand (STA, jumps, LDA, ADD, OR, AND), then the data (LDA,
// ADD, OR, AND): the single memory port makes these three reads in turn.
// A new word is taken only after the result is loaded, so the input side
// holds off each word until the last one is through.
// Reset: acc, pc and halt clear, start_address 0, program_words 256, and
// the whole memory reads as zero at once (per-word valid bits, no sweep).
// A result waits in the output register while m_tready is low; the block
// keeps accepting one more word and holds its result until the output
// register frees up.
module accumulator_cpu_step #(
  parameter int MEM_WORDS = acs_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // opcode[1:0], address[9:2], data[17:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // accumulator[7:0], program_counter[15:8],
                                 // negative_flag[16], zero_flag[17],
                                 // halted[18], read_data[26:19]
);

  acs_pkg::cmd_t    cmd;
  acs_pkg::sts_t    sts;
  acs_pkg::result_t result;

  acs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .item_op  (s_tdata[1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  acs_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_address (s_tdata[9:2]),
    .item_data    (s_tdata[17:10]),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result)
  );

  assign m_tdata = result;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 170;
  localparam logic [7:0] INSTR_SET [11] = '{
    acs_pkg::OP_NOP, acs_pkg::OP_STA, acs_pkg::OP_LDA, acs_pkg::OP_ADD,
    acs_pkg::OP_OR, acs_pkg::OP_AND, acs_pkg::OP_NOT, acs_pkg::OP_JMP,
    acs_pkg::OP_JN, acs_pkg::OP_JZ, acs_pkg::OP_HLT
  };

  // Predicts the machine state and the result word of every command word.
  class cpu_scoreboard;
    logic [7:0]       mem [256];
    logic [7:0]       acc;
    logic [8:0]       pc;
    logic             halt;
    logic [7:0]       start_addr;
    logic [8:0]       word_limit;
    acs_pkg::result_t expected_q [$];
    int               errors;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      acc        = 8'h00;
      pc         = 9'h000;
      halt       = 1'b0;
      start_addr = 8'h00;
      word_limit = 9'd256;
      errors     = 0;
    endfunction

    function bit takes_operand(logic [7:0] b);
      case (b)
        acs_pkg::OP_STA, acs_pkg::OP_LDA, acs_pkg::OP_ADD, acs_pkg::OP_OR,
        acs_pkg::OP_AND, acs_pkg::OP_JMP, acs_pkg::OP_JN, acs_pkg::OP_JZ: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void write_reg(logic idx, logic [8:0] val);
      if (idx == acs_pkg::CFG_START) begin
        start_addr = val[7:0];
      end else begin
        word_limit = val;
      end
    endfunction

    function void run_instr();
      logic [7:0] ir;
      logic [7:0] arg;
      if (halt) return;
      if (pc >= word_limit) begin
        halt = 1'b1;
        return;
      end
      ir  = mem[pc[7:0]];
      arg = 8'h00;
      if (takes_operand(ir)) begin
        arg = mem[pc[7:0] + 8'd1];
        pc  = pc + 9'd2;
      end else begin
        pc = pc + 9'd1;
      end
      case (ir)
        acs_pkg::OP_STA: mem[arg] = acc;
        acs_pkg::OP_LDA: acc = mem[arg];
        acs_pkg::OP_ADD: acc = acc + mem[arg];
        acs_pkg::OP_OR:  acc = acc | mem[arg];
        acs_pkg::OP_AND: acc = acc & mem[arg];
        acs_pkg::OP_NOT: acc = ~acc;
        acs_pkg::OP_JMP: pc = {1'b0, arg};
        acs_pkg::OP_JN:  if (acc[7]) pc = {1'b0, arg};
        acs_pkg::OP_JZ:  if (acc == 8'h00) pc = {1'b0, arg};
        acs_pkg::OP_HLT: halt = 1'b1;
        default: ;
      endcase
      if (pc >= word_limit) halt = 1'b1;
    endfunction

    function void note_word(logic [1:0] op, logic [7:0] addr, logic [7:0] data);
      acs_pkg::result_t r;
      logic [7:0]       rd;
      rd = 8'h00;
      case (op)
        acs_pkg::ITEM_WRITE:   mem[addr] = data;
        acs_pkg::ITEM_READ:    rd = mem[addr];
        acs_pkg::ITEM_RESTART: begin
          pc   = {1'b0, start_addr};
          acc  = 8'h00;
          halt = 1'b0;
        end
        default: run_instr();
      endcase
      r                 = '0;
      r.accumulator     = acc;
      r.program_counter = pc[7:0];
      r.negative_flag   = acc[7];
      r.zero_flag       = (acc == 8'h00);
      r.halted          = halt;
      r.read_data       = rd;
      expected_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [31:0] w);
      acs_pkg::result_t got, want;
      got = acs_pkg::result_t'(w);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, w);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp_field("accumulator", want.accumulator, got.accumulator);
      cmp_field("program_counter", want.program_counter, got.program_counter);
      cmp_field("negative_flag", 8'(want.negative_flag), 8'(got.negative_flag));
      cmp_field("zero_flag", 8'(want.zero_flag), 8'(got.zero_flag));
      cmp_field("halted", 8'(want.halted), 8'(got.halted));
      cmp_field("read_data", want.read_data, got.read_data);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data  = 9'h000;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = 24'h000000;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;

  cpu_scoreboard sb;
  int          cycles   = 0;
  int          send_pct = 0;
  int          recv_pct = 0;
  int          sent     = 0;
  logic [7:0]  prog_base = 8'h00;

  accumulator_cpu_step dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, data, addr, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(op, addr, data);
    sent++;
  endtask

  // drop valid, let every result come back, then cover the longest latency
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sa, input logic [8:0] limit);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= acs_pkg::CFG_START;
    cfg_data  <= {1'b0, sa};
    @(posedge clk);
    sb.write_reg(acs_pkg::CFG_START, {1'b0, sa});
    @(negedge clk);
    cfg_index <= acs_pkg::CFG_WORDS;
    cfg_data  <= limit;
    @(posedge clk);
    sb.write_reg(acs_pkg::CFG_WORDS, limit);
    @(negedge clk);
    cfg_we    <= 1'b0;
    prog_base  = sa;
  endtask

  function automatic logic [7:0] pick_operand(int len);
    int r;
    r = $urandom_range(99);
    if (r < 40) return prog_base + 8'($urandom_range(0, len));
    if (r < 80) return prog_base + 8'd24 + 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // when reload is set, load a short program plus a data pool at the start address; then restart and run it
  task automatic program_burst(input bit reload);
    int         len;
    int         steps;
    int         r;
    logic [7:0] b;
    bit         need_operand;
    len          = $urandom_range(3, 20);
    need_operand = 1'b0;
    if (reload) begin
      for (int i = 0; i < len; i++) begin
        if (need_operand) begin
          b            = pick_operand(len);
          need_operand = 1'b0;
        end else begin
          b            = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 255))
                                                  : INSTR_SET[$urandom_range(0, 10)];
          need_operand = sb.takes_operand(b);
        end
        send_word(acs_pkg::ITEM_WRITE, prog_base + 8'(i), b);
      end
      repeat ($urandom_range(1, 4))
        send_word(acs_pkg::ITEM_WRITE, prog_base + 8'd24 + 8'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
    end
    send_word(acs_pkg::ITEM_RESTART, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    steps = $urandom_range(2, 30);
    repeat (steps) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_word(acs_pkg::ITEM_READ, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end else if (r < 11) begin
        send_word(acs_pkg::ITEM_WRITE, prog_base + 8'd24 + 8'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)));
      end else begin
        send_word(acs_pkg::ITEM_EXEC, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(3, 8))
      send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
  endtask

  initial begin
    int         phase_send;
    int         phase_recv;
    int         target;
    int         r;
    logic [7:0] sa;
    logic [8:0] limit;

    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, wrapping add, untaken branches, unknown byte, halt
    send_word(acs_pkg::ITEM_WRITE, 8'hFF, 8'hFF);
    send_word(acs_pkg::ITEM_WRITE, 8'h00, acs_pkg::OP_LDA);
    send_word(acs_pkg::ITEM_WRITE, 8'h01, 8'hFF);
    send_word(acs_pkg::ITEM_WRITE, 8'h02, acs_pkg::OP_ADD);
    send_word(acs_pkg::ITEM_WRITE, 8'h03, 8'hFF);
    send_word(acs_pkg::ITEM_WRITE, 8'h04, acs_pkg::OP_JZ);
    send_word(acs_pkg::ITEM_WRITE, 8'h05, 8'h00);
    send_word(acs_pkg::ITEM_WRITE, 8'h06, acs_pkg::OP_NOT);
    send_word(acs_pkg::ITEM_WRITE, 8'h07, acs_pkg::OP_JN);
    send_word(acs_pkg::ITEM_WRITE, 8'h08, 8'h0B);
    send_word(acs_pkg::ITEM_WRITE, 8'h0A, 8'h77);
    send_word(acs_pkg::ITEM_WRITE, 8'h0B, acs_pkg::OP_HLT);
    send_word(acs_pkg::ITEM_READ, 8'hFF, 8'h00);
    send_word(acs_pkg::ITEM_READ, 8'h00, 8'hFF);
    send_word(acs_pkg::ITEM_RESTART, 8'h00, 8'h00);
    repeat (9) send_word(acs_pkg::ITEM_EXEC, 8'h00, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin sa = 8'd0;   limit = 9'd256; end
        1: begin sa = 8'd255; limit = 9'd256; end
        2: begin
          sa    = 8'($urandom_range(0, 200));
          limit = 9'(sa) + 9'($urandom_range(8, 55));
        end
        3: begin sa = 8'd250; limit = 9'd511; end
        4: begin sa = 8'd0;   limit = 9'd1; end
        5: begin
          sa    = 8'($urandom_range(0, 255));
          limit = 9'($urandom_range(1, 256));
        end
        default: begin sa = 8'($urandom_range(0, 255)); limit = 9'd0; end
      endcase
      case (p % 4)
        0: begin phase_send = 0;  phase_recv = 0;  end
        1: begin phase_send = 71; phase_recv = 0;  end
        2: begin phase_send = 0;  phase_recv = 71; end
        default: begin phase_send = 31; phase_recv = 31; end
      endcase
      send_pct = 0;
      recv_pct = 0;
      set_config(sa, limit);
      target = sent + PHASE_WORDS;
      while (sent < target) begin
        // some bursts run at full rate even in a stalling phase
        send_pct = ($urandom_range(4) == 0) ? 0 : phase_send;
        recv_pct = ($urandom_range(4) == 0) ? 0 : phase_recv;
        r = $urandom_range(9);
        if (r == 0) begin
          noise_burst();
        end else if (r == 1) begin
          program_burst(1'b0);
        end else begin
          program_burst(1'b1);
        end
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    recv_pct  = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
